// ===== rtl/lrpg_pkg.sv =====
`default_nettype none
package lrpg_pkg;

  // Generator constants
  localparam logic [31:0] LCG_MUL    = 32'd2743;
  localparam logic [31:0] LCG_ADD    = 32'd5923;
  localparam logic [31:0] SEED_RESET = 32'd1;

  // Default cap on the Poisson count
  localparam int unsigned MAX_COUNT_DEF = 255;

  // Request kinds
  localparam logic [1:0] OP_REAL = 2'd0;
  localparam logic [1:0] OP_INT  = 2'd1;
  localparam logic [1:0] OP_POIS = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DRAW,
    ST_PINIT,
    ST_CHECK,
    ST_MUL,
    ST_PUPD,
    ST_OUT
  } lrpg_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic latch;     // capture request fields
    logic draw;      // advance the generator
    logic p_init;    // load product with the first draw
    logic mul;       // register operand times draw
    logic p_upd;     // product takes the scaled multiply result
    logic cnt_inc;   // count one more event
    logic out_load;  // load result register
  } lrpg_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       p_gt_limit;
    logic       cnt_max;
  } lrpg_sts_t;

endpackage
`default_nettype wire

// ===== rtl/lrpg_ctrl.sv =====
`default_nettype none
module lrpg_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 s_valid_i,
  output logic                s_ready_o,
  output logic                m_valid_o,
  input  wire                 m_ready_i,
  input  lrpg_pkg::lrpg_sts_t sts_i,
  output lrpg_pkg::lrpg_cmd_t cmd_o
);

  lrpg_pkg::lrpg_state_e state_q, state_d;
  logic first_q, first_d;
  logic valid_q, valid_d;

  // State, first-draw flag and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lrpg_pkg::ST_IDLE;
      first_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      first_q <= first_d;
      valid_q <= valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d   = state_q;
    first_d   = first_q;
    valid_d   = valid_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;

    // Drop the result once its transfer completes
    if (valid_q && m_ready_i) begin
      valid_d = 1'b0;
    end

    case (state_q)
      lrpg_pkg::ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.latch = 1'b1;
          first_d     = 1'b1;
          state_d     = lrpg_pkg::ST_DRAW;
        end
      end
      lrpg_pkg::ST_DRAW: begin
        // Request kind is registered by now; unused kind takes no draw
        if (sts_i.op == lrpg_pkg::OP_NONE) begin
          state_d = lrpg_pkg::ST_OUT;
        end else begin
          cmd_o.draw = 1'b1;
          if (sts_i.op == lrpg_pkg::OP_REAL) begin
            state_d = lrpg_pkg::ST_OUT;
          end else if (sts_i.op == lrpg_pkg::OP_INT) begin
            state_d = lrpg_pkg::ST_MUL;
          end else if (first_q) begin
            state_d = lrpg_pkg::ST_PINIT;
          end else begin
            state_d = lrpg_pkg::ST_MUL;
          end
        end
      end
      lrpg_pkg::ST_PINIT: begin
        cmd_o.p_init = 1'b1;
        first_d      = 1'b0;
        state_d      = lrpg_pkg::ST_CHECK;
      end
      lrpg_pkg::ST_CHECK: begin
        if (!sts_i.p_gt_limit || sts_i.cnt_max) begin
          state_d = lrpg_pkg::ST_OUT;
        end else begin
          cmd_o.cnt_inc = 1'b1;
          state_d       = lrpg_pkg::ST_DRAW;
        end
      end
      lrpg_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        if (sts_i.op == lrpg_pkg::OP_INT) begin
          state_d = lrpg_pkg::ST_OUT;
        end else begin
          state_d = lrpg_pkg::ST_PUPD;
        end
      end
      lrpg_pkg::ST_PUPD: begin
        cmd_o.p_upd = 1'b1;
        state_d     = lrpg_pkg::ST_CHECK;
      end
      lrpg_pkg::ST_OUT: begin
        // Hold until the result register is free
        if (!valid_q || m_ready_i) begin
          cmd_o.out_load = 1'b1;
          valid_d        = 1'b1;
          state_d        = lrpg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lrpg_pkg::ST_IDLE;
      end
    endcase
  end

  assign m_valid_o = valid_q;

endmodule
`default_nettype wire

// ===== rtl/lrpg_dp.sv =====
`default_nettype none
module lrpg_dp #(
  parameter int unsigned MaxCount = lrpg_pkg::MAX_COUNT_DEF
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  lrpg_pkg::lrpg_cmd_t cmd_i,
  output lrpg_pkg::lrpg_sts_t sts_o,
  input  wire                 cfg_we_i,
  input  wire  [31:0]         cfg_wdata_i,
  input  wire  [95:0]         in_data_i,
  input  wire  [1:0]          in_op_i,
  output logic [31:0]         out_value_o,
  output logic                out_capped_o
);

  localparam int unsigned CntW = $clog2(MaxCount + 1);

  logic [31:0]     seed_q;
  logic [1:0]      op_q;
  logic [31:0]     lo_q, hi_q, limit_q;
  logic [32:0]     span_q;
  logic [30:0]     p_q;
  logic [62:0]     prod_q;
  logic [CntW-1:0] count_q;
  logic [31:0]     value_q;
  logic            capped_q;

  logic [30:0] u;
  logic [31:0] mul_a;
  logic [31:0] seed_prod;
  logic [31:0] scaled;
  logic [31:0] value_d;
  logic        p_gt_limit;

  assign u = seed_q[30:0];

  // Generator word: configuration write restarts it, a draw advances it
  assign seed_prod = seed_q * lrpg_pkg::LCG_MUL;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= lrpg_pkg::SEED_RESET;
    end else if (cfg_we_i) begin
      seed_q <= cfg_wdata_i;
    end else if (cmd_i.draw) begin
      seed_q <= seed_prod + lrpg_pkg::LCG_ADD;
    end
  end

  // Capture request fields, ordering the bounds
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q    <= in_op_i;
      limit_q <= in_data_i[95:64];
      if ($signed(in_data_i[31:0]) > $signed(in_data_i[63:32])) begin
        lo_q <= in_data_i[63:32];
        hi_q <= in_data_i[31:0];
      end else begin
        lo_q <= in_data_i[31:0];
        hi_q <= in_data_i[63:32];
      end
    end
  end

  // Span of the range, exact in 33 bits
  always_ff @(posedge clk_i) begin
    if (cmd_i.draw) begin
      span_q <= {hi_q[31], hi_q} - {lo_q[31], lo_q} + 33'd1;
    end
  end

  // Shared multiplier: span or product times the draw
  assign mul_a = (op_q == lrpg_pkg::OP_INT) ? span_q[31:0] : {1'b0, p_q};
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= 63'(mul_a) * 63'(u);
    end
  end

  // Poisson product and count
  always_ff @(posedge clk_i) begin
    if (cmd_i.p_init) begin
      p_q <= u;
    end else if (cmd_i.p_upd) begin
      p_q <= prod_q[61:31];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      count_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      count_q <= count_q + CntW'(1);
    end
  end

  assign p_gt_limit = {1'b0, p_q} > limit_q;

  // Select the result for the request kind
  assign scaled = span_q[32] ? {u, 1'b0} : prod_q[62:31];
  always_comb begin
    case (op_q)
      lrpg_pkg::OP_REAL: value_d = {1'b0, u};
      lrpg_pkg::OP_INT:  value_d = lo_q + scaled;
      lrpg_pkg::OP_POIS: value_d = 32'(count_q);
      default:           value_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      value_q  <= value_d;
      capped_q <= (op_q == lrpg_pkg::OP_POIS) && p_gt_limit;
    end
  end

  assign sts_o.op         = op_q;
  assign sts_o.p_gt_limit = p_gt_limit;
  assign sts_o.cnt_max    = count_q >= CntW'(MaxCount);

  assign out_value_o  = value_q;
  assign out_capped_o = capped_q;

endmodule
`default_nettype wire

// ===== rtl/lcg_random_poisson_generator.sv =====
// Random number source: a 32-bit linear congruential generator
// (word * 2743 + 5923) serving three request kinds on one stream.
// Input channel s_axis: tuser carries the request kind (uniform fraction,
// ranged integer, Poisson count); tdata carries the two integer bounds and
// the Poisson limit exp(-mean) in Q0.31. Output channel m_axis: tdata is the
// result, tuser flags a Poisson count saturated at MAX_COUNT.
// The configuration write loads the generator word directly and restarts
// the sequence; write it only while no request is in flight.
// One request is worked on at a time, stepped by the controller through a
// single LCG multiplier and one shared 32x31 multiplier. A uniform request
// takes one draw, an integer request a draw and a multiply, the unused kind
// no draw; a Poisson request takes a first draw, then one draw, multiply and
// product update per counted event. A new request is accepted only after
// the last one's result is loaded. Reset loads the generator word with 1,
// idles the controller and clears the output valid. A finished result waits
// in the output register while the receiver stalls; the next request is still
// accepted and works until it needs to load that register, where it holds.
`default_nettype none
module lcg_random_poisson_generator #(
  parameter int unsigned MAX_COUNT = lrpg_pkg::MAX_COUNT_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // Configuration: seed_start
  input  wire         cfg_we_i,
  input  wire  [31:0] cfg_wdata_i,
  // Requests
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [95:0] s_axis_tdata,   // range_low, range_high, poisson_limit
  input  wire  [1:0]  s_axis_tuser,   // op
  // Results
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata,   // value
  output logic        m_axis_tuser    // capped
);

  lrpg_pkg::lrpg_cmd_t cmd;
  lrpg_pkg::lrpg_sts_t sts;

  // Sequencer
  lrpg_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // Generator and arithmetic
  lrpg_dp #(
    .MaxCount (MAX_COUNT)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_data_i    (s_axis_tdata),
    .in_op_i      (s_axis_tuser),
    .out_value_o  (m_axis_tdata),
    .out_capped_o (m_axis_tuser)
  );

endmodule
`default_nettype wire
